// File: rtl/core/aso_pkg.sv
// ----------------------------------------------------------------------------
// aso_pkg
// Word types and shift-type codes for the ARM shifter operand block.
// ----------------------------------------------------------------------------
package aso_pkg;

    // Shift type, instruction bits 6:5
    typedef enum logic [1:0] {
        SHIFT_LSL = 2'd0,
        SHIFT_LSR = 2'd1,
        SHIFT_ASR = 2'd2,
        SHIFT_ROR = 2'd3
    } shift_kind_t;

    // One instruction word on the input channel
    typedef struct packed {
        logic        imm_select;
        logic [11:0] operand_field;
        logic [31:0] rm_value;
        logic [7:0]  rs_low_byte;
        logic        carry_in;
    } instr_word_t;

    // One result word on the output channel
    typedef struct packed {
        logic [31:0] operand_out;
        logic        carry_out;
        logic        bad_encoding;
    } result_word_t;

endpackage

// File: rtl/core/aso_if.sv
// ----------------------------------------------------------------------------
// aso_instr_if / aso_result_if
// Valid/ready channels carrying instruction and result words.
// ----------------------------------------------------------------------------
interface aso_instr_if
    import aso_pkg::*;
();
    logic        valid;
    logic        ready;
    instr_word_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface aso_result_if
    import aso_pkg::*;
();
    logic         valid;
    logic         ready;
    result_word_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/core/arm_shifter_operand.sv
// ----------------------------------------------------------------------------
// arm_shifter_operand
// ARM data-processing shifter operand and carry-out, one word per cycle while the result side drains.
//
//   Channel   Role   Word
//   instr     sink   imm_select, operand_field, rm_value, rs_low_byte, carry_in
//   result    source operand_out, carry_out, bad_encoding
//
// The path runs through an input register, the shifter logic and a result
// register. A new word is taken every cycle while the result side drains.
// A stall on result holds the result register; the input register still
// takes a word if it is empty. Reset clears both valid flags only.
// ----------------------------------------------------------------------------
module arm_shifter_operand
    import aso_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    aso_instr_if.sink    instr,
    aso_result_if.source result
);

    logic         in_valid_reg;
    instr_word_t  in_word_reg;
    logic         out_valid_reg;
    result_word_t out_word_reg;

    result_word_t shift_result;
    logic         out_advance;
    logic         in_advance;

    aso_shifter u_shifter (
        .word   (in_word_reg),
        .result (shift_result)
    );

    // Result register frees when empty or taken; input register when it moves on
    assign out_advance = !out_valid_reg || result.ready;
    assign in_advance  = !in_valid_reg || out_advance;

    assign instr.ready    = in_advance;
    assign result.valid   = out_valid_reg;
    assign result.payload = out_word_reg;

    // Advance valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_advance)
            begin
                in_valid_reg <= instr.valid;
            end
            if (out_advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // Capture words
    always_ff @(posedge clk)
    begin
        if (in_advance && instr.valid)
        begin
            in_word_reg <= instr.payload;
        end
        if (out_advance && in_valid_reg)
        begin
            out_word_reg <= shift_result;
        end
    end

endmodule

// File: rtl/core/aso_shifter.sv
// ----------------------------------------------------------------------------
// aso_shifter
// Combinational addressing-mode-1 shifter: decodes the operand field and
// produces the shifter operand, carry-out and the bad-encoding flag.
// ----------------------------------------------------------------------------
module aso_shifter
    import aso_pkg::*;
(
    input  instr_word_t  word,
    output result_word_t result
);

    logic [7:0]  imm8;
    logic [3:0]  imm_rot;
    logic [63:0] imm_pair;
    logic [31:0] imm_res;

    shift_kind_t kind;
    logic [4:0]  imm_amt;
    logic [7:0]  amt;
    logic [31:0] rm;

    logic [32:0] lsl_wide;
    logic [32:0] lsr_wide;
    logic [32:0] asr_wide;
    logic [63:0] ror_pair;
    logic [31:0] ror_res;

    logic [31:0] sh_res;
    logic        sh_carry;

    assign imm8     = word.operand_field[7:0];
    assign imm_rot  = word.operand_field[11:8];
    assign imm_pair = {24'd0, imm8, 24'd0, imm8} >> {imm_rot, 1'b0};
    assign imm_res  = imm_pair[31:0];

    assign kind    = shift_kind_t'(word.operand_field[6:5]);
    assign imm_amt = word.operand_field[11:7];
    assign rm      = word.rm_value;

    // Pick the shift amount: immediate LSR/ASR of zero means 32
    always_comb
    begin
        if (word.operand_field[4])
        begin
            amt = word.rs_low_byte;
        end
        else if (imm_amt == 5'd0)
        begin
            amt = 8'd32;
        end
        else
        begin
            amt = {3'd0, imm_amt};
        end
    end

    // Shift with the carry bit carried one place beyond the word
    assign lsl_wide = {1'b0, rm} << amt[4:0];
    assign lsr_wide = {rm, 1'b0} >> amt[4:0];
    assign asr_wide = 33'($signed({rm, 1'b0}) >>> amt[4:0]);
    assign ror_pair = {rm, rm} >> amt[4:0];
    assign ror_res  = ror_pair[31:0];

    // Architectural results for each type, amount zero first
    always_comb
    begin
        sh_res   = rm;
        sh_carry = word.carry_in;
        if (amt != 8'd0)
        begin
            case (kind)
                SHIFT_LSL:
                begin
                    if (amt < 8'd32)
                    begin
                        sh_res   = lsl_wide[31:0];
                        sh_carry = lsl_wide[32];
                    end
                    else
                    begin
                        sh_res   = '0;
                        sh_carry = (amt == 8'd32) ? rm[0] : 1'b0;
                    end
                end
                SHIFT_LSR:
                begin
                    if (amt < 8'd32)
                    begin
                        sh_res   = lsr_wide[32:1];
                        sh_carry = lsr_wide[0];
                    end
                    else
                    begin
                        sh_res   = '0;
                        sh_carry = (amt == 8'd32) ? rm[31] : 1'b0;
                    end
                end
                SHIFT_ASR:
                begin
                    if (amt < 8'd32)
                    begin
                        sh_res   = asr_wide[32:1];
                        sh_carry = asr_wide[0];
                    end
                    else
                    begin
                        sh_res   = {32{rm[31]}};
                        sh_carry = rm[31];
                    end
                end
                default:
                begin
                    // Rotate uses the low five bits; bit 31 of the result is the carry
                    sh_res   = ror_res;
                    sh_carry = ror_res[31];
                end
            endcase
        end
    end

    // Select the form
    always_comb
    begin
        result.operand_out  = '0;
        result.carry_out    = 1'b0;
        result.bad_encoding = 1'b0;
        if (word.imm_select)
        begin
            result.operand_out = imm_res;
            result.carry_out   = (imm_rot == 4'd0) ? word.carry_in : imm_res[31];
        end
        else if (word.operand_field[4] && word.operand_field[7])
        begin
            result.bad_encoding = 1'b1;
        end
        else if (!word.operand_field[4] && (imm_amt == 5'd0) && (kind == SHIFT_LSL))
        begin
            result.operand_out = rm;
            result.carry_out   = word.carry_in;
        end
        else if (!word.operand_field[4] && (imm_amt == 5'd0) && (kind == SHIFT_ROR))
        begin
            // RRX
            result.operand_out = {word.carry_in, rm[31:1]};
            result.carry_out   = rm[0];
        end
        else
        begin
            result.operand_out = sh_res;
            result.carry_out   = sh_carry;
        end
    end

endmodule
